// ===== src/rlp_pkg.sv =====
// Package for the running largest prime block.
// Holds the value widths, the first trial divisor and the item types.
// No dependencies.
`timescale 1ns / 1ps

package rlp_pkg;

  localparam int VALUE_WIDTH = 31;
  localparam int DIV_WIDTH = (VALUE_WIDTH + 1) / 2 + 1;
  localparam int SQ_WIDTH = 2 * DIV_WIDTH;
  localparam int CNT_WIDTH = $clog2(VALUE_WIDTH);

  localparam logic [DIV_WIDTH-1:0] FIRST_DIVISOR = DIV_WIDTH'(2);

  typedef struct packed {
    logic [VALUE_WIDTH-1:0] value;
    logic                   new_scan;
  } in_item_t;

  typedef struct packed {
    logic [VALUE_WIDTH-1:0] largest_prime;
    logic                   value_was_new_prime;
  } out_item_t;

endpackage

// ===== src/running_largest_prime.sv =====
// Top level: keeps the largest prime of an integer stream, tested by trial division.
// A microcoded sequencer drives a squarer and a one-bit-per-cycle remainder unit.
// Depends on rlp_pkg.
// Each item is accepted and checked; a candidate then loops over trial divisors, squaring
// each one, checking the bound and taking the remainder one bit per cycle, until the
// square exceeds the value (prime) or a remainder is zero (rejected); then the result
// is emitted.
// One item is in work at a time; the next item is taken once the result is registered.
// Reset clears the stored prime to zero and sends the sequencer to its accept step.
`timescale 1ns / 1ps

module running_largest_prime import rlp_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  in_item_t  in_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_item_t out_o
);

  typedef enum logic [3:0] {
    STEP_ACCEPT = 4'd0,
    STEP_CHECK  = 4'd1,
    STEP_SQUARE = 4'd2,
    STEP_BOUND  = 4'd3,
    STEP_DIVIDE = 4'd4,
    STEP_NEXTD  = 4'd5,
    STEP_REJECT = 4'd6,
    STEP_PRIME  = 4'd7,
    STEP_EMIT   = 4'd8
  } step_e;

  typedef enum logic [3:0] {
    ACT_LOAD,
    ACT_INIT_D,
    ACT_SQUARE,
    ACT_INIT_DIV,
    ACT_DIV_STEP,
    ACT_INC_D,
    ACT_REJECT,
    ACT_PRIME,
    ACT_EMIT
  } act_e;

  typedef enum logic [2:0] {
    CND_NEVER,
    CND_ALWAYS,
    CND_NO_ACCEPT,
    CND_NOT_CAND,
    CND_SQ_GT,
    CND_DIV_BUSY,
    CND_REM_NONZERO,
    CND_OUT_BLOCKED
  } cond_e;

  typedef struct packed {
    act_e  act;
    cond_e cond;
    step_e target;
    step_e next;
  } uword_t;

  localparam logic [CNT_WIDTH-1:0] LAST_BIT = CNT_WIDTH'(VALUE_WIDTH - 1);

  // The microprogram: the jump target is taken when the condition holds.
  function automatic uword_t rom_word(input step_e pc);
    uword_t w;
    unique case (pc)
      STEP_ACCEPT: w = '{ACT_LOAD,     CND_NO_ACCEPT,   STEP_ACCEPT, STEP_CHECK};
      STEP_CHECK:  w = '{ACT_INIT_D,   CND_NOT_CAND,    STEP_REJECT, STEP_SQUARE};
      STEP_SQUARE: w = '{ACT_SQUARE,   CND_NEVER,       STEP_SQUARE, STEP_BOUND};
      STEP_BOUND:  w = '{ACT_INIT_DIV, CND_SQ_GT,       STEP_PRIME,  STEP_DIVIDE};
      STEP_DIVIDE: w = '{ACT_DIV_STEP, CND_DIV_BUSY,    STEP_DIVIDE, STEP_NEXTD};
      STEP_NEXTD:  w = '{ACT_INC_D,    CND_REM_NONZERO, STEP_SQUARE, STEP_REJECT};
      STEP_REJECT: w = '{ACT_REJECT,   CND_ALWAYS,      STEP_EMIT,   STEP_EMIT};
      STEP_PRIME:  w = '{ACT_PRIME,    CND_NEVER,       STEP_PRIME,  STEP_EMIT};
      STEP_EMIT:   w = '{ACT_EMIT,     CND_OUT_BLOCKED, STEP_EMIT,   STEP_ACCEPT};
      default:     w = '{ACT_REJECT,   CND_ALWAYS,      STEP_ACCEPT, STEP_ACCEPT};
    endcase
    return w;
  endfunction

  step_e                  pc_q, pc_d;
  logic                   out_valid_q, out_valid_d;
  logic [VALUE_WIDTH-1:0] best_q, best_d;
  out_item_t              out_q, out_d;
  logic [VALUE_WIDTH-1:0] v_q, v_d;
  logic [DIV_WIDTH-1:0]   d_q, d_d;
  logic [SQ_WIDTH-1:0]    sq_q, sq_d;
  logic [DIV_WIDTH-1:0]   rem_q, rem_d;
  logic [CNT_WIDTH-1:0]   cnt_q, cnt_d;
  logic                   flag_q, flag_d;

  uword_t                 uw;
  logic                   jump;
  logic                   blocked;
  logic [CNT_WIDTH-1:0]   bit_idx;
  logic [DIV_WIDTH:0]     trial;
  logic [DIV_WIDTH:0]     diff;
  logic                   fits;

  always_comb begin
    uw      = rom_word(pc_q);
    blocked = out_valid_q && out_stall_i;
    bit_idx = LAST_BIT - cnt_q;
    trial   = {rem_q, v_q[bit_idx]};
    diff    = trial - {1'b0, d_q};
    fits    = trial >= {1'b0, d_q};

    out_valid_d = out_valid_q;
    out_d       = out_q;
    best_d      = best_q;
    v_d         = v_q;
    d_d         = d_q;
    sq_d        = sq_q;
    rem_d       = rem_q;
    cnt_d       = cnt_q;
    flag_d      = flag_q;

    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    unique case (uw.act)
      ACT_LOAD: begin
        if (in_valid_i) begin
          v_d = in_i.value;
          if (in_i.new_scan) begin
            best_d = '0;
          end
        end
      end
      ACT_INIT_D:   d_d = FIRST_DIVISOR;
      ACT_SQUARE:   sq_d = d_q * d_q;
      ACT_INIT_DIV: begin
        rem_d = '0;
        cnt_d = '0;
      end
      ACT_DIV_STEP: begin
        rem_d = fits ? diff[DIV_WIDTH-1:0] : trial[DIV_WIDTH-1:0];
        cnt_d = cnt_q + CNT_WIDTH'(1);
      end
      ACT_INC_D:    d_d = d_q + DIV_WIDTH'(1);
      ACT_REJECT:   flag_d = 1'b0;
      ACT_PRIME: begin
        flag_d = 1'b1;
        best_d = v_q;
      end
      ACT_EMIT: begin
        if (!blocked) begin
          out_valid_d                 = 1'b1;
          out_d.largest_prime         = best_q;
          out_d.value_was_new_prime   = flag_q;
        end
      end
      default: ;
    endcase

    unique case (uw.cond)
      CND_NEVER:       jump = 1'b0;
      CND_ALWAYS:      jump = 1'b1;
      CND_NO_ACCEPT:   jump = !in_valid_i;
      CND_NOT_CAND:    jump = !((v_q > best_q) &&
                                (v_q >= VALUE_WIDTH'(FIRST_DIVISOR)));
      CND_SQ_GT:       jump = sq_q > SQ_WIDTH'(v_q);
      CND_DIV_BUSY:    jump = cnt_q != LAST_BIT;
      CND_REM_NONZERO: jump = rem_q != '0;
      CND_OUT_BLOCKED: jump = blocked;
      default:         jump = 1'b0;
    endcase

    pc_d = jump ? uw.target : uw.next;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q        <= STEP_ACCEPT;
      out_valid_q <= 1'b0;
      best_q      <= '0;
    end else begin
      pc_q        <= pc_d;
      out_valid_q <= out_valid_d;
      best_q      <= best_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    v_q    <= v_d;
    d_q    <= d_d;
    sq_q   <= sq_d;
    rem_q  <= rem_d;
    cnt_q  <= cnt_d;
    flag_q <= flag_d;
  end

  assign in_stall_o  = pc_q != STEP_ACCEPT;
  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

endmodule

// ===== src/rlp_checker.sv =====
// Port-level checker for the running largest prime block, bound to its top level.
// Depends on rlp_pkg and running_largest_prime.
`timescale 1ns / 1ps

module rlp_checker import rlp_pkg::*; (
  input logic      clk_i,
  input logic      rst_ni,
  input logic      in_valid_i,
  input logic      in_stall_o,
  input in_item_t  in_i,
  input logic      out_valid_o,
  input logic      out_stall_i,
  input out_item_t out_o
);

  // A stalled result item stays offered.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_o))
    else $error("stalled result item changed or dropped");

  // A new prime is odd, or it is two.
  a_prime_odd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_o.value_was_new_prime |->
      out_o.largest_prime[0] || out_o.largest_prime == VALUE_WIDTH'(2))
    else $error("reported prime is even");

  // An accepted item keeps the block busy, so the next one is not taken at once.
  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("item taken while another is in work");

  // A reported new prime is never zero or one.
  a_flag_grow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_o.value_was_new_prime |->
      out_o.largest_prime >= VALUE_WIDTH'(2))
    else $error("new prime reported below two");

endmodule

bind running_largest_prime rlp_checker u_rlp_checker (.*);

// ===== dv/tb_running_largest_prime.sv =====
// Testbench for running_largest_prime: directed and random integer streams with idle
// bursts on both channels, results checked against a trial-division scoreboard.
// Depends on rlp_pkg and running_largest_prime.
`timescale 1ns / 1ps

module tb_running_largest_prime;
  import rlp_pkg::*;

  class prime_scoreboard;
    logic [VALUE_WIDTH-1:0] best_prime;
    out_item_t              prime_reports_q[$];
    int                     mismatches;
    int                     items_seen;
    int                     new_primes;
    int                     scan_clears;

    function new();
      best_prime  = '0;
      mismatches  = 0;
      items_seen  = 0;
      new_primes  = 0;
      scan_clears = 0;
    endfunction

    function bit passes_trial_division(logic [VALUE_WIDTH-1:0] candidate);
      longint unsigned n;
      longint unsigned d;
      n = 64'(candidate);
      if (n < longint'(FIRST_DIVISOR)) return 1'b0;
      for (d = longint'(FIRST_DIVISOR); d * d <= n; d++) begin
        if (n % d == 0) return 1'b0;
      end
      return 1'b1;
    endfunction

    function void note_item(in_item_t item);
      out_item_t report;
      items_seen++;
      if (item.new_scan) begin
        best_prime = '0;
        scan_clears++;
      end
      report.value_was_new_prime = 1'b0;
      if (item.value > best_prime && passes_trial_division(item.value)) begin
        best_prime = item.value;
        report.value_was_new_prime = 1'b1;
        new_primes++;
      end
      report.largest_prime = best_prime;
      prime_reports_q.push_back(report);
    endfunction

    function void check_item(out_item_t got);
      out_item_t want;
      if (prime_reports_q.size() == 0) begin
        $error("unexpected result: largest_prime %0d, value_was_new_prime %0d",
               got.largest_prime, got.value_was_new_prime);
        mismatches++;
        return;
      end
      want = prime_reports_q.pop_front();
      if (got.largest_prime !== want.largest_prime) begin
        $error("largest_prime: expected %0d, actual %0d", want.largest_prime,
               got.largest_prime);
        mismatches++;
      end
      if (got.value_was_new_prime !== want.value_was_new_prime) begin
        $error("value_was_new_prime: expected %0d, actual %0d", want.value_was_new_prime,
               got.value_was_new_prime);
        mismatches++;
      end
    endfunction
  endclass

  logic      clk_i       = 1'b0;
  logic      rst_ni      = 1'b0;
  logic      in_valid_i  = 1'b0;
  logic      in_stall_o;
  in_item_t  in_i        = '0;
  logic      out_valid_o;
  logic      out_stall_i = 1'b0;
  out_item_t out_o;

  bit              quiet_run = 1'b0;
  prime_scoreboard board     = new();

  running_largest_prime i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_i        (in_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_o       (out_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      board.check_item(out_o);
    end
  end

  initial begin : result_stall_gen
    int burst;
    burst = 0;
    forever begin
      @(negedge clk_i);
      if (burst > 0) begin
        out_stall_i <= 1'b1;
        burst--;
      end else begin
        out_stall_i <= 1'b0;
        if (!quiet_run && $urandom_range(0, 5) == 0) burst = $urandom_range(1, 10);
      end
    end
  end

  task automatic hold_off_sender(int cycles);
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    repeat (cycles - 1) @(negedge clk_i);
  endtask

  task automatic send_item(in_item_t item);
    if (!quiet_run && $urandom_range(0, 3) == 0) hold_off_sender($urandom_range(1, 10));
    @(negedge clk_i);
    in_valid_i <= 1'b1;
    in_i       <= item;
    do @(posedge clk_i); while (in_stall_o);
    board.note_item(item);
  endtask

  task automatic send_value(bit scan, int unsigned value);
    in_item_t item;
    item.new_scan = scan;
    item.value    = value[VALUE_WIDTH-1:0];
    send_item(item);
  endtask

  task automatic wait_drained();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (board.prime_reports_q.size() != 0) @(posedge clk_i);
  endtask

  function automatic in_item_t random_item();
    in_item_t    item;
    int unsigned pick;
    int unsigned factor;
    int unsigned best;
    pick          = $urandom_range(0, 99);
    best          = 32'(board.best_prime);
    item.new_scan = ($urandom_range(0, 9) == 0);
    if (pick < 40) begin
      item.value = VALUE_WIDTH'($urandom_range(0, 2000));
    end else if (pick < 55) begin
      // A product with a small factor stays cheap to reject at any magnitude.
      factor     = $urandom_range(2, 97);
      item.value = VALUE_WIDTH'(factor * $urandom_range(1, 32'h7FFF_FFFF / factor));
    end else if (pick < 65) begin
      item.value = VALUE_WIDTH'($urandom_range(0, 65535));
    end else if (pick < 75) begin
      item.value = VALUE_WIDTH'($urandom & 32'h7FFF_FFFE);
    end else if (pick < 88) begin
      item.value = VALUE_WIDTH'(best + $urandom_range(1, 200));
    end else begin
      item.value = VALUE_WIDTH'(best - $urandom_range(0, best));
    end
    return item;
  endfunction

  initial begin : stimulus
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    send_value(1'b0, 0);
    send_value(1'b0, 1);
    send_value(1'b0, 2);
    send_value(1'b0, 2);
    send_value(1'b0, 3);
    send_value(1'b0, 4);
    send_value(1'b0, 9);
    send_value(1'b0, 25);
    send_value(1'b0, 23);
    send_value(1'b0, 19);
    send_value(1'b0, 961);
    send_value(1'b0, 997);
    send_value(1'b0, 32'h7FFF_FFFE);
    send_value(1'b0, 32'h7FFF_FFFD);
    send_value(1'b1, 5);
    send_value(1'b1, 0);
    send_value(1'b0, 1);
    send_value(1'b0, 65521);
    send_value(1'b0, 65521);
    send_value(1'b0, 1018081);
    send_value(1'b0, 1000003);
    send_value(1'b0, 32'h5555_5555);
    send_value(1'b0, 32'h2AAA_AAAA);
    send_value(1'b1, 1);
    send_value(1'b1, 32'h7FFF_FFFE);
    wait_drained();

    for (int n = 0; n < 75; n++) begin
      if (n == 60) quiet_run = 1'b1;
      if (!quiet_run && $urandom_range(0, 24) == 0) wait_drained();
      send_item(random_item());
    end

    wait_drained();
    repeat (20) @(posedge clk_i);
    $display("Sent %0d items, %0d of them new largest primes, with %0d scan restarts.",
             board.items_seen, board.new_primes, board.scan_clears);
    if (board.mismatches == 0 && board.prime_reports_q.size() == 0) begin
      $display("tb_running_largest_prime: PASS");
    end else begin
      $display("tb_running_largest_prime: FAIL");
    end
    $finish;
  end

  initial begin : watchdog
    #100_000_000;
    $display("tb_running_largest_prime: FAIL");
    $finish;
  end

endmodule

// ===== running_largest_prime.f =====
src/rlp_pkg.sv
src/running_largest_prime.sv
src/rlp_checker.sv
dv/tb_running_largest_prime.sv
